[rtl/mi_pkg.sv]
// ----------------------------------------------------------------------------
// mi_pkg
// shared widths, register map and controller/datapath interface types
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int K_W        = $clog2(DATA_WIDTH);
  localparam int ADDR_WIDTH = 3;

  // register index, taken from paddr bit 2
  localparam logic REG_MODULUS = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new word and the modulus
    logic shift_up;  // align divisor one more bit
    logic reduce;    // conditional subtract, shift divisor back down
    logic last;      // last reduce of a step: swap the remainder pair
    logic sign_upd;  // swap also advances the coefficient signs
    logic finish;    // normalize and write the result register
  } mi_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic m_zero;
    logic d_zero;
    logic can_shift;
    logic k_zero;
  } mi_stat_t;

endpackage

[rtl/mi_dp.sv]
// ----------------------------------------------------------------------------
// mi_dp
// extended euclid datapath: shift-subtract quotient steps and result register
// ----------------------------------------------------------------------------
module mi_dp (
  input  logic                          clk,
  input  mi_pkg::mi_cmd_t               cmd,
  output mi_pkg::mi_stat_t              stat,
  input  logic [mi_pkg::DATA_WIDTH-1:0] value_in,
  input  logic [mi_pkg::DATA_WIDTH-1:0] modulus_in,
  output logic [mi_pkg::DATA_WIDTH-1:0] inverse,
  output logic                          invertible
);
  import mi_pkg::*;

  logic [DATA_WIDTH-1:0] rem;   // r0
  logic [DATA_WIDTH-1:0] acc;   // |coefficient of r0|
  logic [DATA_WIDTH-1:0] d;     // r1, shifted during a step
  logic [DATA_WIDTH-1:0] dm;    // |coefficient of r1|, shifted with d
  logic [K_W-1:0]        k;
  logic                  neg0;
  logic                  neg1;
  logic [DATA_WIDTH-1:0] mreg;

  logic                  ge;
  logic [DATA_WIDTH-1:0] rem_red;
  logic [DATA_WIDTH-1:0] acc_red;
  logic                  ok;
  logic [DATA_WIDTH-1:0] mag_mod;
  logic [DATA_WIDTH-1:0] norm;

  always_comb begin
    ge      = (rem >= d);
    rem_red = ge ? (rem - d) : rem;
    acc_red = ge ? (acc + dm) : acc;
    ok      = (mreg != '0) && (rem == DATA_WIDTH'(1));
    // coefficient magnitude never exceeds the modulus: one subtract reduces it
    mag_mod = (acc >= mreg) ? (acc - mreg) : acc;
    norm    = (neg0 && (mag_mod != '0)) ? (mreg - mag_mod) : mag_mod;
  end

  assign stat.m_zero    = (mreg == '0);
  assign stat.d_zero    = (d == '0);
  assign stat.can_shift = ({d, 1'b0} <= {1'b0, rem});
  assign stat.k_zero    = (k == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= value_in;
      acc  <= DATA_WIDTH'(1);
      d    <= modulus_in;
      dm   <= '0;
      k    <= '0;
      neg0 <= 1'b0;
      neg1 <= 1'b0;
      mreg <= modulus_in;
    end else if (cmd.shift_up) begin
      d  <= {d[DATA_WIDTH-2:0], 1'b0};
      dm <= {dm[DATA_WIDTH-2:0], 1'b0};
      k  <= k + 1'b1;
    end else if (cmd.reduce) begin
      if (cmd.last) begin
        rem <= d;
        d   <= rem_red;
        acc <= dm;
        dm  <= acc_red;
        if (cmd.sign_upd) begin
          neg0 <= neg1;
          neg1 <= ~neg1;
        end
      end else begin
        rem <= rem_red;
        acc <= acc_red;
        d   <= {1'b0, d[DATA_WIDTH-1:1]};
        dm  <= {1'b0, dm[DATA_WIDTH-1:1]};
        k   <= k - 1'b1;
      end
    end
    if (cmd.finish) begin
      invertible <= ok;
      inverse    <= ok ? norm : '0;
    end
  end

endmodule

[rtl/mi_ctrl.sv]
// ----------------------------------------------------------------------------
// mi_ctrl
// controller: sequences the quotient steps and owns both handshakes
// ----------------------------------------------------------------------------
module mi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mi_pkg::mi_cmd_t  cmd,
  input  mi_pkg::mi_stat_t stat
);
  import mi_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_ALIGN  = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pre;  // first pass reduces value modulo the modulus

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = stat.m_zero ? S_FINISH : S_ALIGN;
      end
      S_ALIGN: begin
        if (stat.d_zero) begin
          state_next = S_FINISH;
        end else if (stat.can_shift) begin
          cmd.shift_up = 1'b1;
        end else begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (stat.k_zero) begin
          cmd.last     = 1'b1;
          cmd.sign_upd = ~pre;
          state_next   = S_ALIGN;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pre       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        pre <= 1'b1;
      end else if (cmd.reduce && cmd.last) begin
        pre <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_START))
    else $error("accepted word did not start a computation");

  a_pre_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALIGN && pre) |-> !stat.d_zero)
    else $error("zero divisor during initial reduction");

  a_reduce_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE && !stat.k_zero) |=> (state == S_REDUCE))
    else $error("reduce left before shift count reached zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result word raised outside finish");

endmodule

[rtl/modular_inverse_top.sv]
// ----------------------------------------------------------------------------
// modular_inverse_top
// modular inverse by the extended euclidean algorithm, apb modulus register
// ----------------------------------------------------------------------------
// run time: grows with k summed over the euclid steps, k = number of align
//   shifts in the step (bit length of the quotient minus one, zero for a zero
//   quotient), counting the initial value-mod-modulus pass as a step; a zero
//   modulus goes straight to finish; the one shared shift-subtract unit does
//   one align or reduce step per cycle
// throughput: one word at a time; the next word is taken while a result waits,
//   but its finish stalls until that result is accepted
// reset: rst synchronous active high, modulus returns to 1, no word in flight
// ----------------------------------------------------------------------------
module modular_inverse_top (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mi_pkg::DATA_WIDTH-1:0] value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mi_pkg::DATA_WIDTH-1:0] inverse,
  output logic                          invertible,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mi_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mi_pkg::*;

  logic [DATA_WIDTH-1:0] modulus;
  mi_cmd_t               cmd;
  mi_stat_t              stat;
  logic                  reg_hit;

  // register index is paddr bit 2; byte lane bits are ignored
  assign reg_hit = (paddr[2] == REG_MODULUS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? modulus : '0;

  // modulus register: user writes it only while no word is in flight; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= DATA_WIDTH'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      modulus <= pwdata;
    end
  end

  // controller: accept, step sequencing, result handshake
  mi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: remainder and coefficient registers, normalization, result word
  mi_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .value_in   (value),
    .modulus_in (modulus),
    .inverse    (inverse),
    .invertible (invertible)
  );

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// checks modular_inverse_top against a behavioral extended euclid inverse.
// words go in through a valid/ready channel with random gaps, results come
// back through a second channel with random back-pressure, and each result is
// compared field by field with the prediction made when its word was taken.
// the modulus register is written over the apb port between phases only,
// with the block idle, and read back after every write.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import mi_pkg::*;

  // generous run limit: covers roughly 430 words several times over
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // drain time after the last result, before the verdict is printed
  localparam int unsigned DRAIN_CYCLES = 300;

  // register map: index sits at paddr bit 2, byte offset 4 per register
  localparam logic [ADDR_WIDTH-1:0] MODULUS_ADDR  = {REG_MODULUS, 2'b00};
  localparam logic [ADDR_WIDTH-1:0] UNMAPPED_ADDR = {~REG_MODULUS, 2'b00};

  typedef struct packed {
    logic [DATA_WIDTH-1:0] inverse;
    logic                  invertible;
  } inv_result_t;

  // clock, reset and every block input start at known values
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [DATA_WIDTH-1:0] value      = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [DATA_WIDTH-1:0] inverse;
  logic                  invertible;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr      = '0;
  logic [31:0]           pwdata     = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // words waiting to be sent, and predictions waiting for their result
  logic [DATA_WIDTH-1:0] pending_values[$];
  inv_result_t           awaited_inverses[$];

  // copy of the modulus register as the block should hold it
  logic [31:0]           modulus_shadow = 32'd1;

  // when set, neither side inserts gaps or stalls
  bit                    steady = 1'b0;

  int unsigned           send_gap    = 0;
  int unsigned           recv_stall  = 0;
  int unsigned           cycle_count = 0;
  int unsigned           error_count = 0;

  modular_inverse_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inverse    (inverse),
    .invertible (invertible),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // extended euclid with sign-magnitude coefficients; the coefficients
  // alternate in sign and never exceed the modulus, so 64 bits is plenty
  function automatic inv_result_t modular_inverse_of(input logic [DATA_WIDTH-1:0] word,
                                                     input logic [DATA_WIDTH-1:0] modn);
    logic [63:0] rem_prev, rem_cur, rem_next, quot;
    logic [63:0] coef_prev, coef_cur, coef_next;
    logic        neg_prev, neg_cur;
    inv_result_t res;
    res.inverse    = '0;
    res.invertible = 1'b0;
    // a zero modulus has no inverse at all
    if (modn == '0) return res;
    rem_prev  = 64'(modn);
    rem_cur   = 64'(word) % 64'(modn);
    coef_prev = 64'd0;
    neg_prev  = 1'b0;
    coef_cur  = 64'd1;
    neg_cur   = 1'b0;
    while (rem_cur != 64'd0) begin
      quot      = rem_prev / rem_cur;
      rem_next  = rem_prev - quot * rem_cur;
      coef_next = coef_prev + quot * coef_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_prev = coef_cur;
      neg_prev  = neg_cur;
      coef_cur  = coef_next;
      neg_cur   = ~neg_cur;
    end
    // gcd other than one: no inverse
    if (rem_prev != 64'd1) return res;
    // fold a negative coefficient back into 0 .. modulus-1
    coef_prev = coef_prev % 64'(modn);
    if (neg_prev && coef_prev != 64'd0) coef_prev = 64'(modn) - coef_prev;
    res.inverse    = coef_prev[DATA_WIDTH-1:0];
    res.invertible = 1'b1;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // helpers
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // gap length for either side: mostly none, some short, a few long
  function automatic int unsigned idle_length();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random word shaped around the current modulus
  function automatic logic [DATA_WIDTH-1:0] shaped_value(input logic [31:0] modn);
    logic [63:0] wide;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: wide = 64'($urandom);
      4:          wide = 64'($urandom_range(0, 255));
      // just below the modulus
      5:          wide = 64'(modn) - 64'($urandom_range(1, 8));
      // at or above the modulus, reduced first by the block
      6:          wide = 64'(modn) * 64'($urandom_range(1, 3)) + 64'($urandom_range(0, 7));
      // a multiple of the modulus: never invertible unless it is one
      7:          wide = 64'(modn) * 64'($urandom_range(0, 65535));
      8:          wide = 64'(32'hFFFF_FFFF) - 64'($urandom_range(0, 15));
      default:    wide = 64'd1 << $urandom_range(0, DATA_WIDTH - 1);
    endcase
    return wide[DATA_WIDTH-1:0];
  endfunction

  // ------------------------------------------------------------------------
  // input driver: one word in flight on the channel, fed from pending_values
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      // channel free: either idle or the current word was just taken
      if (in_valid && in_ready) begin
        awaited_inverses.push_back(modular_inverse_of(value, modulus_shadow[DATA_WIDTH-1:0]));
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_valid <= 1'b1;
        value    <= pending_values.pop_front();
        send_gap <= idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // result monitor with random back-pressure
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    int unsigned stall;
    inv_result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_inverses.size() == 0) begin
          report_mismatch($sformatf("unexpected word inverse=%0h invertible=%0b",
                                    inverse, invertible));
        end else begin
          want = awaited_inverses.pop_front();
          if (invertible !== want.invertible)
            report_mismatch($sformatf("invertible got %0b want %0b",
                                      invertible, want.invertible));
          if (inverse !== want.inverse)
            report_mismatch($sformatf("inverse got %0h want %0h",
                                      inverse, want.inverse));
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else begin
        stall = idle_length();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready  <= 1'b0;
          recv_stall <= stall - 1;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // run limit
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // apb access and phase control
  // ------------------------------------------------------------------------

  // read the modulus back and compare with the shadow copy
  task automatic check_modulus_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODULUS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== modulus_shadow)
      report_mismatch($sformatf("modulus readback got %0h want %0h", prdata, modulus_shadow));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // setup cycle, access cycle, then hold until pready
  task automatic apb_write(input logic [ADDR_WIDTH-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // an unmapped index leaves the modulus alone
    if (addr[2] == REG_MODULUS) modulus_shadow = data;
    check_modulus_readback();
  endtask

  // wait until every word is sent and every result is back; sampled on the
  // falling edge so the driver and monitor have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_values.size() != 0 || in_valid || awaited_inverses.size() != 0)
      @(negedge clk);
  endtask

  task automatic random_phase(input logic [31:0] modn, input int unsigned count);
    apb_write(MODULUS_ADDR, modn);
    steady = ($urandom_range(0, 3) == 0);
    repeat (count) pending_values.push_back(shaped_value(modn));
    wait_drained();
  endtask

  initial begin : stimulus
    logic [31:0] rand_mod;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, back to back
    steady = 1'b1;

    // reset modulus of one: everything inverts to zero
    check_modulus_readback();
    pending_values.push_back(32'h0000_0000);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h0000_3039);
    wait_drained();

    // zero modulus: nothing is invertible; a write to an unmapped index is ignored
    apb_write(MODULUS_ADDR, 32'h0000_0000);
    apb_write(UNMAPPED_ADDR, 32'h0000_0007);
    pending_values.push_back(32'h0000_0000);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'h0000_0007);
    wait_drained();

    // largest 32-bit prime: zero, one, edges around the modulus, top values
    apb_write(MODULUS_ADDR, 32'hFFFF_FFFB);
    pending_values.push_back(32'h0000_0000);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'h0000_0002);
    pending_values.push_back(32'hFFFF_FFFA);
    pending_values.push_back(32'hFFFF_FFFB);
    pending_values.push_back(32'hFFFF_FFFC);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    wait_drained();

    // all-ones modulus, a composite with small factors
    apb_write(MODULUS_ADDR, 32'hFFFF_FFFF);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'hFFFF_FFFE);
    pending_values.push_back(32'h0000_0003);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'h0000_0002);
    wait_drained();

    // smallest nontrivial modulus
    apb_write(MODULUS_ADDR, 32'h0000_0002);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'hFFFF_FFFF);
    wait_drained();

    // random part: about 400 words over a spread of moduli
    rand_mod = $urandom | 32'h8000_0000;
    random_phase(rand_mod, 50);
    random_phase(32'($urandom_range(2, 1000)), 50);
    random_phase(32'hFFFF_FFFB, 50);
    random_phase(32'hFFFF_FFFF, 50);
    random_phase(32'h8000_0000, 40);
    rand_mod = $urandom | 32'h0000_0001;
    random_phase(rand_mod, 50);
    random_phase(32'($urandom_range(2, 65535)), 50);
    random_phase(32'h0000_0001, 10);
    random_phase($urandom, 50);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[modular_inverse_top.f]
rtl/mi_pkg.sv
rtl/mi_dp.sv
rtl/mi_ctrl.sv
rtl/modular_inverse_top.sv
dv/testbench.sv
